@@ hw/rtl/sgf_record_splitter_defines.svh @@
// assertion helpers for the record splitter checker
`ifndef SGF_RECORD_SPLITTER_DEFINES_SVH
`define SGF_RECORD_SPLITTER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define SGF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sgf_record_splitter check failed");

// next-cycle implication, quiet while reset is held
`define SGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sgf_record_splitter check failed");

`endif

@@ hw/rtl/sgfrs_pkg.sv @@
package sgfrs_pkg;

    localparam int unsigned LINE_W = 24;
    localparam int unsigned REC_W  = 17;
    localparam int unsigned LIMIT_W = 16;

    // input beat codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // stream characters of interest
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // register byte addresses
    localparam logic [2:0] ADDR_RECORD_LIMIT = 3'd0;

    typedef enum logic [1:0] {
        KIND_APPEND       = 2'd0,
        KIND_APPEND_CLOSE = 2'd1,
        KIND_DISCARD      = 2'd2,
        KIND_CLOSE_BUF    = 2'd3
    } t_kind;

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        out_byte;
        logic              tag_error;
        logic [LINE_W-1:0] line_number;
    } t_out_item;

    // parser flags and counters, all but the nesting depth
    typedef struct packed {
        logic              in_value;
        logic              escape_pending;
        logic              skipping_lead;
        logic [LINE_W-1:0] line_count;
        logic [REC_W-1:0]  records_closed;
    } t_flags;

endpackage

@@ hw/rtl/sgfrs_step.sv @@
module sgfrs_step #(
    parameter int unsigned NESTING_WIDTH = 16
) (
    input  sgfrs_pkg::t_in_item                   i_item,
    input  sgfrs_pkg::t_flags                     i_flags,
    input  logic signed [NESTING_WIDTH-1:0]       i_depth,
    input  logic [sgfrs_pkg::LIMIT_W-1:0]         i_record_limit,
    output sgfrs_pkg::t_flags                     o_flags,
    output logic signed [NESTING_WIDTH-1:0]       o_depth,
    output logic                                  o_res_valid,
    output sgfrs_pkg::t_out_item                  o_res
);

    localparam logic signed [NESTING_WIDTH-1:0] DEPTH_MAX =
        {1'b0, {(NESTING_WIDTH-1){1'b1}}};
    localparam logic signed [NESTING_WIDTH-1:0] DEPTH_MIN =
        {1'b1, {(NESTING_WIDTH-1){1'b0}}};
    localparam logic signed [NESTING_WIDTH-1:0] DEPTH_ONE =
        {{(NESTING_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [sgfrs_pkg::LINE_W-1:0] LINE_ONE =
        {{(sgfrs_pkg::LINE_W-1){1'b0}}, 1'b1};
    localparam logic [sgfrs_pkg::REC_W-1:0] REC_ONE =
        {{(sgfrs_pkg::REC_W-1){1'b0}}, 1'b1};

    logic [7:0] b;
    logic       is_space;
    logic       stopped;
    logic signed [NESTING_WIDTH-1:0] depth_dec;

    assign b        = i_item.in_byte;
    assign is_space = (b == sgfrs_pkg::CH_SPACE) ||
                      ((b >= sgfrs_pkg::CH_TAB) && (b <= sgfrs_pkg::CH_CR));
    assign stopped  = i_flags.records_closed > {1'b0, i_record_limit};
    assign depth_dec = (i_depth > DEPTH_MIN) ? (i_depth - DEPTH_ONE) : i_depth;

    always_comb begin
        o_flags     = i_flags;
        o_depth     = i_depth;
        o_res_valid = 1'b0;
        o_res.kind        = sgfrs_pkg::KIND_APPEND;
        o_res.out_byte    = b;
        o_res.tag_error   = 1'b0;
        o_res.line_number = i_flags.line_count;

        if (i_item.op == sgfrs_pkg::OP_END) begin
            // report the partial buffer if no record has closed, then start a fresh stream
            o_res_valid    = (i_flags.records_closed == '0);
            o_res.kind     = sgfrs_pkg::KIND_CLOSE_BUF;
            o_res.out_byte = '0;
            o_flags        = '0;
            o_depth        = '0;
        end else if (stopped) begin
            o_res_valid = 1'b0;
        end else if (i_flags.escape_pending) begin
            o_flags.escape_pending = 1'b0;
            o_res_valid            = 1'b1;
        end else if (i_flags.skipping_lead) begin
            if (!is_space) begin
                o_flags.skipping_lead = 1'b0;
            end
        end else begin
            if ((b == sgfrs_pkg::CH_NEWLINE) && (i_flags.line_count != '1)) begin
                o_flags.line_count = i_flags.line_count + LINE_ONE;
            end
            o_res.line_number = o_flags.line_count;
            o_res_valid       = 1'b1;

            if (b == sgfrs_pkg::CH_BACKSLASH) begin
                o_flags.escape_pending = 1'b1;
            end else if ((b == sgfrs_pkg::CH_LPAREN) && !i_flags.in_value) begin
                if (i_depth < DEPTH_MAX) begin
                    o_depth = i_depth + DEPTH_ONE;
                end
                if (i_depth == '0) begin
                    o_flags.skipping_lead = 1'b1;
                    o_res.kind            = sgfrs_pkg::KIND_DISCARD;
                    o_res.out_byte        = '0;
                end
            end else if ((b == sgfrs_pkg::CH_RPAREN) && !i_flags.in_value) begin
                o_depth = depth_dec;
                if (depth_dec == '0) begin
                    if (i_flags.records_closed != '1) begin
                        o_flags.records_closed = i_flags.records_closed + REC_ONE;
                    end
                    o_res.kind = sgfrs_pkg::KIND_APPEND_CLOSE;
                end
            end else if ((b == sgfrs_pkg::CH_LBRACK) && !i_flags.in_value) begin
                o_flags.in_value = 1'b1;
            end else if (b == sgfrs_pkg::CH_RBRACK) begin
                o_res.tag_error  = !i_flags.in_value;
                o_flags.in_value = 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/sgf_record_splitter.sv @@
// sgf_record_splitter: takes a byte stream of game records, one byte (or an
// end-of-stream marker) per input beat, and gives at most one result beat per
// input beat telling the downstream buffer what to do: append the byte, append
// it and close the record, discard the buffer, or close the buffer as a record.
// A new beat is accepted every clock cycle while the output side keeps up; a
// result reaches the output through the input register, then the result
// register. Beats that cause no result are consumed all the same. The
// record_limit register (byte address 0, reset 65535) should be written only
// while the block is idle; once record_limit + 1 records have closed, bytes
// are dropped until end of stream.
module sgf_record_splitter #(
    parameter int unsigned NESTING_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte stream in
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sgfrs_pkg::t_in_item   i_in,
    // result beats out
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sgfrs_pkg::t_out_item  o_out,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // input stage
    logic                 r_in_valid, n_in_valid;
    sgfrs_pkg::t_in_item  r_in,       n_in;

    // parser state
    sgfrs_pkg::t_flags               r_flags, n_flags;
    logic signed [NESTING_WIDTH-1:0] r_depth, n_depth;

    // result stage
    logic                  r_out_valid, n_out_valid;
    sgfrs_pkg::t_out_item  r_out,       n_out;

    // configuration
    logic [sgfrs_pkg::LIMIT_W-1:0] r_record_limit, n_record_limit;

    // combinational step results
    sgfrs_pkg::t_flags               step_flags;
    logic signed [NESTING_WIDTH-1:0] step_depth;
    logic                            step_valid;
    sgfrs_pkg::t_out_item            step_res;

    logic advance;    // the held input beat is processed this cycle
    logic cfg_write;

    sgfrs_step #(
        .NESTING_WIDTH (NESTING_WIDTH)
    ) u_step (
        .i_item         (r_in),
        .i_flags        (r_flags),
        .i_depth        (r_depth),
        .i_record_limit (r_record_limit),
        .o_flags        (step_flags),
        .o_depth        (step_depth),
        .o_res_valid    (step_valid),
        .o_res          (step_res)
    );

    // the held beat moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr == sgfrs_pkg::ADDR_RECORD_LIMIT) begin
            prdata = {{(32-sgfrs_pkg::LIMIT_W){1'b0}}, r_record_limit};
        end
    end

    always_comb begin
        n_in_valid     = r_in_valid;
        n_in           = r_in;
        n_flags        = r_flags;
        n_depth        = r_depth;
        n_out_valid    = r_out_valid;
        n_out          = r_out;
        n_record_limit = r_record_limit;

        // result register drains when taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (advance) begin
            n_flags = step_flags;
            n_depth = step_depth;
            if (step_valid) begin
                n_out_valid = 1'b1;
                n_out       = step_res;
            end
        end

        // input register: refill on accept, else empty once processed
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
            n_in       = i_in;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        // only the upper address bit selects a register, index 0 is the limit
        if (cfg_write && (paddr[2] == sgfrs_pkg::ADDR_RECORD_LIMIT[2])) begin
            n_record_limit = pwdata[sgfrs_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_flags        <= '0;
            r_depth        <= '0;
            r_out_valid    <= 1'b0;
            r_record_limit <= '1;
        end else begin
            r_in_valid     <= n_in_valid;
            r_flags        <= n_flags;
            r_depth        <= n_depth;
            r_out_valid    <= n_out_valid;
            r_record_limit <= n_record_limit;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hw/rtl/sgfrs_checker.sv @@
`include "sgf_record_splitter_defines.svh"

module sgfrs_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input sgfrs_pkg::t_out_item  o_out
);

    logic out_stall;
    logic no_byte_kind;
    logic tag_shape;
    logic close_kind;
    logic close_shape;

    assign out_stall    = o_out_valid && !i_out_ready;
    assign no_byte_kind = (o_out.kind == sgfrs_pkg::KIND_DISCARD) ||
                          (o_out.kind == sgfrs_pkg::KIND_CLOSE_BUF);
    assign tag_shape    = (o_out.kind == sgfrs_pkg::KIND_APPEND) &&
                          (o_out.out_byte == sgfrs_pkg::CH_RBRACK);
    assign close_kind   = (o_out.kind == sgfrs_pkg::KIND_APPEND_CLOSE);
    assign close_shape  = (o_out.out_byte == sgfrs_pkg::CH_RPAREN) && !o_out.tag_error;

    // a stalled result beat stays put
    `SGF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out))

    // discard and buffer close carry no byte
    `SGF_ASSERT_NOW(a_no_byte, i_clk, i_rst_n, o_out_valid && no_byte_kind, o_out.out_byte == '0)

    // tag errors only come with an appended closing bracket
    `SGF_ASSERT_NOW(a_tag_bracket, i_clk, i_rst_n, o_out_valid && o_out.tag_error, tag_shape)

    // a record closes only on a closing parenthesis
    `SGF_ASSERT_NOW(a_close_paren, i_clk, i_rst_n, o_out_valid && close_kind, close_shape)

endmodule

bind sgf_record_splitter sgfrs_checker u_sgfrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
